// ===== hw/rtl/aosf_pkg.sv =====
package aosf_pkg;

  localparam int CFG_W = 9;
  localparam int COORD_W = 8;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  typedef struct packed {
    logic pixel;
    logic col_zero;
    logic row_zero;
    logic end_mat;
  } item_flags_t;

  typedef enum logic [0:0] {
    REG_MATRIX_SIDE = 1'b0,
    REG_SQUARE_SIDE = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    CLR_BUSY = 2'b01,
    CLR_DONE = 2'b10
  } clr_state_e;

endpackage

// ===== hw/rtl/aosf_front.sv =====
module aosf_front #(
  parameter int IDXW = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      pixel_i,
  output logic                      in_stall_o,
  input  logic                      clear_busy_i,
  input  logic                      q_full_i,
  input  logic [aosf_pkg::CFG_W-1:0] n_side_i,
  output logic                      push_o,
  output aosf_pkg::item_flags_t     flags_o,
  output logic [IDXW-1:0]           row_o,
  output logic [IDXW-1:0]           col_o
);
  import aosf_pkg::*;

  logic [IDXW-1:0] row_q, row_d;
  logic [IDXW-1:0] col_q, col_d;
  logic            end_row;
  logic            end_mat;

  // position compares against N-1 with N >= 1
  assign end_row = (32'(col_q) + 32'd1) >= 32'(n_side_i);
  assign end_mat = end_row && ((32'(row_q) + 32'd1) >= 32'(n_side_i));

  assign in_stall_o = q_full_i || clear_busy_i;
  assign push_o     = in_valid_i && !in_stall_o;

  assign flags_o.pixel    = pixel_i;
  assign flags_o.col_zero = (col_q == '0);
  assign flags_o.row_zero = (row_q == '0);
  assign flags_o.end_mat  = end_mat;
  assign row_o = row_q;
  assign col_o = col_q;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (push_o) begin
      if (end_row) begin
        col_d = '0;
        row_d = end_mat ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

// ===== hw/rtl/aosf_queue.sv =====
module aosf_queue #(
  parameter int W     = 20,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    return (32'(p) == DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (32'(count_q) == DEPTH);
  assign valid_o = (count_q != '0);
  assign data_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop_i) rd_ptr_q <= next_ptr(rd_ptr_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/aosf_back.sv =====
module aosf_back #(
  parameter int MAX_SIDE = 256,
  parameter int IDXW     = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  aosf_pkg::item_flags_t        q_flags_i,
  input  logic [IDXW-1:0]              q_row_i,
  input  logic [IDXW-1:0]              q_col_i,
  output logic                         pop_o,
  input  logic [aosf_pkg::CFG_W-1:0]   m_side_i,
  output logic                         clear_busy_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         found_o,
  output logic [aosf_pkg::COORD_W-1:0] corner_row_o,
  output logic [aosf_pkg::COORD_W-1:0] corner_col_o,
  output logic                         last_pixel_o
);
  import aosf_pkg::*;

  localparam int CW = (IDXW > CFG_W) ? IDXW : CFG_W;

  clr_state_e  clr_state_q, clr_state_d;
  logic [IDXW-1:0] clr_cnt_q;

  logic [CFG_W-1:0] heights_mem [MAX_SIDE];
  logic [CFG_W-1:0] rdata_q;

  logic             b_valid_q;
  item_flags_t      b_flags_q;
  logic [IDXW-1:0]  b_row_q, b_col_q;
  logic [CFG_W-1:0] run_q;

  logic             b_adv;
  logic [CFG_W-1:0] prev_run, run_next, prev_h, h_next;
  logic             found;
  logic             mem_we;
  logic [IDXW-1:0]  mem_waddr;
  logic [CFG_W-1:0] mem_wdata;

  logic             out_valid_q;
  logic             found_q, last_q;
  logic [COORD_W-1:0] corner_row_q, corner_col_q;

  assign clear_busy_o = (clr_state_q == CLR_BUSY);

  // clearing pass after reset: steps through every column of the height store, then stays done
  always_comb begin
    clr_state_d = clr_state_q;
    unique case (clr_state_q)
      CLR_BUSY: if (32'(clr_cnt_q) == MAX_SIDE - 1) clr_state_d = CLR_DONE;
      CLR_DONE: clr_state_d = CLR_DONE;
      default:  clr_state_d = CLR_BUSY;
    endcase
  end

  assign b_adv = b_valid_q && (!out_valid_q || !out_stall_i);
  assign pop_o = q_valid_i && !clear_busy_o && (!b_valid_q || b_adv);

  // run and height update, both saturating at M
  always_comb begin
    prev_run = b_flags_q.col_zero ? '0 : run_q;
    if (!b_flags_q.pixel) begin
      run_next = '0;
    end else begin
      run_next = (prev_run >= m_side_i) ? m_side_i : prev_run + 1'b1;
    end
    prev_h = b_flags_q.row_zero ? '0 : rdata_q;
    if (run_next >= m_side_i) begin
      h_next = (prev_h >= m_side_i) ? m_side_i : prev_h + 1'b1;
    end else begin
      h_next = '0;
    end
    found = (h_next >= m_side_i);
  end

  assign mem_we    = clear_busy_o || b_adv;
  assign mem_waddr = clear_busy_o ? clr_cnt_q : b_col_q;
  assign mem_wdata = clear_busy_o ? '0 : h_next;

  // read issued with the pop; a write to the same column in that cycle is bypassed
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      heights_mem[mem_waddr] <= mem_wdata;
    end
    if (pop_o) begin
      if (b_adv && (b_col_q == q_col_i)) begin
        rdata_q <= h_next;
      end else begin
        rdata_q <= heights_mem[q_col_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_flags_q <= q_flags_i;
      b_row_q   <= q_row_i;
      b_col_q   <= q_col_i;
    end
    if (b_adv) begin
      found_q      <= found;
      last_q       <= b_flags_q.end_mat;
      corner_row_q <= found ? COORD_W'(CW'(b_row_q) - CW'(m_side_i) + 1'b1) : '0;
      corner_col_q <= found ? COORD_W'(CW'(b_col_q) - CW'(m_side_i) + 1'b1) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_state_q <= CLR_BUSY;
      clr_cnt_q   <= '0;
      b_valid_q   <= 1'b0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clr_state_q <= clr_state_d;
      if (clear_busy_o) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (pop_o) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
      if (b_adv) run_q <= run_next;
      if (b_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign corner_row_o = corner_row_q;
  assign corner_col_o = corner_col_q;
  assign last_pixel_o = last_q;

  a_no_work_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_busy_o |-> (!b_valid_q && !out_valid_q))
    else $error("item in flight during clearing pass");

  a_clear_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clear_busy_o) |-> (clr_cnt_q == IDXW'(MAX_SIDE % (1 << IDXW))))
    else $error("clearing pass ended early");

  a_height_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_adv |-> ((h_next <= m_side_i) && (run_next <= m_side_i)))
    else $error("count above square side");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_adv |=> (out_valid_q && (last_q == $past(b_flags_q.end_mat))))
    else $error("result not loaded");

endmodule

// ===== hw/rtl/all_ones_square_finder_core.sv =====
// Channel  Direction  Handshake                Payload
// in       sink       in_valid_i / in_stall_o  pixel_i
// out      source     out_valid_o / out_stall_i found_o, corner_row_o, corner_col_o, last_pixel_o
// cfg      APB slave  psel/penable/pwrite      paddr, pwdata, prdata (matrix_side, square_side)
//
// One item per clock sustained while out_stall_i is low; an accepted item passes the queue, the
// back-end stage and the output register before its result is valid. The per-column height
// store is read-modify-written as items pass, with a bypass for same-column back-to-back writes.
// After reset a clearing pass zeroes all MAX_SIDE entries of the height store; in_stall_o is
// high meanwhile. A four-entry queue lets the input side keep accepting while the output
// is stalled.
module all_ones_square_finder_core #(
  parameter int MAX_SIDE = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          found_o,
  output logic [aosf_pkg::COORD_W-1:0]  corner_row_o,
  output logic [aosf_pkg::COORD_W-1:0]  corner_col_o,
  output logic                          last_pixel_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [aosf_pkg::ADDR_W-1:0]   paddr,
  input  logic [aosf_pkg::DATA_W-1:0]   pwdata,
  output logic [aosf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import aosf_pkg::*;

  localparam int IDXW  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int QW    = $bits(item_flags_t) + 2 * IDXW;
  localparam int QDEPTH = 4;

  logic [CFG_W-1:0] matrix_side_q, square_side_q;
  logic [CFG_W-1:0] n_side, m_side;
  reg_idx_e         reg_idx;
  logic             cfg_we;

  logic             push, pop, q_full, q_valid, clear_busy;
  item_flags_t      f_flags, q_flags;
  logic [IDXW-1:0]  f_row, f_col, q_row, q_col;
  logic [QW-1:0]    q_dout;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_MATRIX_SIDE: prdata = DATA_W'(matrix_side_q);
      REG_SQUARE_SIDE: prdata = DATA_W'(square_side_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_side_q <= CFG_W'(256);
      square_side_q <= CFG_W'(2);
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_MATRIX_SIDE: matrix_side_q <= pwdata[CFG_W-1:0];
        REG_SQUARE_SIDE: square_side_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // zero counts as one, anything above MAX_SIDE as MAX_SIDE
  function automatic logic [CFG_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
    if (v == '0) return CFG_W'(1);
    if (32'(v) > MAX_SIDE) return CFG_W'(MAX_SIDE);
    return v;
  endfunction

  assign n_side = clamp_side(matrix_side_q);
  assign m_side = clamp_side(square_side_q);

  aosf_front #(
    .IDXW (IDXW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .pixel_i      (pixel_i),
    .in_stall_o   (in_stall_o),
    .clear_busy_i (clear_busy),
    .q_full_i     (q_full),
    .n_side_i     (n_side),
    .push_o       (push),
    .flags_o      (f_flags),
    .row_o        (f_row),
    .col_o        (f_col)
  );

  aosf_queue #(
    .W     (QW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_flags, f_row, f_col}),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_dout)
  );

  assign q_flags = item_flags_t'(q_dout[QW-1 -: $bits(item_flags_t)]);
  assign q_row   = q_dout[2*IDXW-1 -: IDXW];
  assign q_col   = q_dout[IDXW-1:0];

  aosf_back #(
    .MAX_SIDE (MAX_SIDE),
    .IDXW     (IDXW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_flags_i    (q_flags),
    .q_row_i      (q_row),
    .q_col_i      (q_col),
    .pop_o        (pop),
    .m_side_i     (m_side),
    .clear_busy_o (clear_busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .found_o      (found_o),
    .corner_row_o (corner_row_o),
    .corner_col_o (corner_col_o),
    .last_pixel_o (last_pixel_o)
  );

endmodule

// ===== bench/square_hit_checker.sv =====
`timescale 1ns / 100ps
module square_hit_checker #(
  parameter int MAX_SIDE = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         pixel,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         found,
  input  logic [aosf_pkg::COORD_W-1:0] corner_row,
  input  logic [aosf_pkg::COORD_W-1:0] corner_col,
  input  logic                         last_pixel,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [aosf_pkg::ADDR_W-1:0]  paddr,
  input  logic [aosf_pkg::DATA_W-1:0]  pwdata,
  input  logic [aosf_pkg::DATA_W-1:0]  prdata,
  output int                           mismatch_count,
  output int                           hits_owed
);
  import aosf_pkg::*;

  localparam int IDXW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } square_hit_t;

  square_hit_t pending_hits[$];

  logic [CFG_W-1:0]   matrix_side_q;
  logic [CFG_W-1:0]   square_side_q;
  logic [COORD_W-1:0] row_q;
  logic [COORD_W-1:0] col_q;
  logic [CFG_W-1:0]   run_q;
  logic [CFG_W-1:0]   heights_q [MAX_SIDE];
  int                 fails = 0;

  assign mismatch_count = fails;

  function automatic int unsigned eff_side(logic [CFG_W-1:0] raw);
    if (raw == '0) return 1;
    if (32'(raw) > MAX_SIDE) return MAX_SIDE;
    return 32'(raw);
  endfunction

  function automatic int unsigned sat_inc(int unsigned v, int unsigned limit);
    return (v >= limit) ? limit : v + 1;
  endfunction

  task automatic note_fail(input string what, input square_hit_t want, input square_hit_t got);
    fails++;
    if (fails <= 10)
      $display("%0t %s: expected found=%0d row=%0d col=%0d last=%0d,",
               $time, what, want.found, want.row, want.col, want.last,
               " got found=%0d row=%0d col=%0d last=%0d",
               got.found, got.row, got.col, got.last);
  endtask

  // advance the scan by one pixel and work out the result it yields
  task automatic scan_pixel(input logic px, output square_hit_t hit);
    int unsigned n, m, row, col, prev_run, prev_h, run, h;
    logic end_row, end_mat;
    n = eff_side(matrix_side_q);
    m = eff_side(square_side_q);
    row = 32'(row_q);
    col = 32'(col_q);
    end_row = col >= n - 1;
    end_mat = end_row && row >= n - 1;
    // first column drops the old run, first row drops the stored heights
    prev_run = (col == 0) ? 0 : 32'(run_q);
    prev_h = (row == 0) ? 0 : 32'(heights_q[IDXW'(col)]);
    run = px ? sat_inc(prev_run, m) : 0;
    h = (run >= m) ? sat_inc(prev_h, m) : 0;
    run_q = CFG_W'(run);
    heights_q[IDXW'(col)] = CFG_W'(h);
    hit.found = h >= m;
    hit.row = hit.found ? COORD_W'(row - (m - 1)) : '0;
    hit.col = hit.found ? COORD_W'(col - (m - 1)) : '0;
    hit.last = end_mat;
    if (end_row) begin
      col_q = '0;
      row_q = end_mat ? '0 : COORD_W'(row + 1);
    end else begin
      col_q = COORD_W'(col + 1);
    end
  endtask

  always @(posedge clk or negedge rst_n) begin
    square_hit_t want, got;
    logic [CFG_W-1:0] reg_val;
    if (!rst_n) begin
      matrix_side_q = CFG_W'(256);
      square_side_q = CFG_W'(2);
      row_q = '0;
      col_q = '0;
      run_q = '0;
      for (int i = 0; i < MAX_SIDE; i++) heights_q[i] = '0;
      pending_hits.delete();
      hits_owed <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        scan_pixel(pixel, want);
        pending_hits.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = {found, corner_row, corner_col, last_pixel};
        if (pending_hits.size() == 0) begin
          note_fail("unexpected result", '0, got);
        end else begin
          want = pending_hits.pop_front();
          if (got !== want) note_fail("result mismatch", want, got);
        end
      end
      if (psel && penable && pready) begin
        case (reg_idx_e'(paddr[ADDR_W-1:2]))
          REG_MATRIX_SIDE: reg_val = matrix_side_q;
          default:         reg_val = square_side_q;
        endcase
        if (pwrite) begin
          case (reg_idx_e'(paddr[ADDR_W-1:2]))
            REG_MATRIX_SIDE: matrix_side_q = pwdata[CFG_W-1:0];
            default:         square_side_q = pwdata[CFG_W-1:0];
          endcase
        end else if (prdata !== DATA_W'(reg_val)) begin
          fails++;
          if (fails <= 10)
            $display("%0t register read at %0d: expected %0h, got %0h",
                     $time, paddr, DATA_W'(reg_val), prdata);
        end
      end
      hits_owed <= pending_hits.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
module tb;
  import aosf_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               pixel_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               found_o;
  logic [COORD_W-1:0] corner_row_o;
  logic [COORD_W-1:0] corner_col_o;
  logic               last_pixel_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  bit                 quiet_run = 1'b0;
  int                 mismatch_count;
  int                 hits_owed;

  always #6 clk_i = ~clk_i;

  all_ones_square_finder_core dut (.*);

  square_hit_checker square_check (
    .clk            (clk_i),
    .rst_n          (rst_ni),
    .in_valid       (in_valid_i),
    .in_stall       (in_stall_o),
    .pixel          (pixel_i),
    .out_valid      (out_valid_o),
    .out_stall      (out_stall_i),
    .found          (found_o),
    .corner_row     (corner_row_o),
    .corner_col     (corner_col_o),
    .last_pixel     (last_pixel_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .mismatch_count (mismatch_count),
    .hits_owed      (hits_owed)
  );

  always @(posedge clk_i) begin
    out_stall_i <= !quiet_run && ($urandom_range(99) < 31);
  end

  task automatic push_pixel(input logic px);
    while (!quiet_run && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i <= px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // stop sending and wait until every pixel's result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (hits_owed != 0) @(posedge clk_i);
  endtask

  task automatic reg_access(input reg_idx_e idx, input logic wr, input logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // upper data bits are junk, only the low field is kept
  task automatic set_reg(input reg_idx_e idx, input logic [CFG_W-1:0] val);
    reg_access(idx, 1'b1, {(DATA_W - CFG_W)'($urandom), val});
    reg_access(idx, 1'b0, '0);
  endtask

  initial begin
    int unsigned nside, mside, eff_n, density, len, pick;
    int unsigned random_items, phase;
    random_items = 0;
    phase = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset sides, first row only
    push_pixel(1'b1);
    push_pixel(1'b1);
    push_pixel(1'b0);
    push_pixel(1'b1);
    drain();
    // shrink mid-row: current column is past the new end of row
    set_reg(REG_MATRIX_SIDE, 9'd3);
    set_reg(REG_SQUARE_SIDE, 9'd2);
    repeat (7) push_pixel(1'b1);
    drain();
    // zero sides count as one
    set_reg(REG_MATRIX_SIDE, 9'd0);
    set_reg(REG_SQUARE_SIDE, 9'd0);
    push_pixel(1'b0);
    push_pixel(1'b1);
    drain();
    // square bigger than the matrix
    set_reg(REG_SQUARE_SIDE, 9'd300);
    set_reg(REG_MATRIX_SIDE, 9'd2);
    repeat (4) push_pixel(1'b1);
    drain();
    set_reg(REG_MATRIX_SIDE, 9'd511);
    set_reg(REG_SQUARE_SIDE, 9'd1);
    push_pixel(1'b1);
    push_pixel(1'b0);
    push_pixel(1'b1);

    while (random_items < 1000) begin
      drain();
      pick = $urandom_range(99);
      if (pick < 70) nside = $urandom_range(1, 12);
      else if (pick < 80) nside = $urandom_range(13, 40);
      else if (pick < 85) nside = 256;
      else if (pick < 90) nside = 0;
      else nside = $urandom_range(257, 511);
      eff_n = (nside == 0) ? 1 : (nside > 256) ? 256 : nside;
      pick = $urandom_range(99);
      if (pick < 70) mside = $urandom_range(1, 5);
      else if (pick < 85) mside = $urandom_range(1, eff_n + 2);
      else if (pick < 90) mside = 0;
      else if (pick < 95) mside = 256;
      else mside = $urandom_range(257, 511);
      case ($urandom_range(4))
        0: set_reg(REG_MATRIX_SIDE, CFG_W'(nside));
        1: set_reg(REG_SQUARE_SIDE, CFG_W'(mside));
        2: begin
          set_reg(REG_SQUARE_SIDE, CFG_W'(mside));
          set_reg(REG_MATRIX_SIDE, CFG_W'(nside));
        end
        default: begin
          set_reg(REG_MATRIX_SIDE, CFG_W'(nside));
          set_reg(REG_SQUARE_SIDE, CFG_W'(mside));
        end
      endcase
      case ($urandom_range(3))
        0: density = 100;
        1: density = 90;
        2: density = 75;
        default: density = 50;
      endcase
      len = $urandom_range(1, (3 * eff_n * eff_n > 150) ? 150 : 3 * eff_n * eff_n);
      for (int i = 0; i < len; i++) begin
        if (phase == 5 && i == len / 2) drain();
        push_pixel($urandom_range(99) < density);
      end
      random_items += len;
      phase++;
    end

    // one-pixel matrix wraps the scan back to the first pixel
    drain();
    set_reg(REG_MATRIX_SIDE, 9'd1);
    push_pixel(1'b0);
    drain();
    // one full matrix at full rate, reaching the far corner
    set_reg(REG_MATRIX_SIDE, 9'd10);
    set_reg(REG_SQUARE_SIDE, 9'd2);
    quiet_run = 1'b1;
    repeat (10 * 10) push_pixel($urandom_range(99) < 75);
    drain();
    repeat (4) @(posedge clk_i);

    if (mismatch_count == 0 && hits_owed == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== all_ones_square_finder_core.f =====
hw/rtl/aosf_pkg.sv
hw/rtl/aosf_front.sv
hw/rtl/aosf_queue.sv
hw/rtl/aosf_back.sv
hw/rtl/all_ones_square_finder_core.sv
bench/square_hit_checker.sv
bench/tb.sv
